/* sv/hrx_pkg.sv */
`default_nettype none

package hrx_pkg;

    localparam int TREE_DEPTH    = 256;
    localparam int TREE_AW       = $clog2(TREE_DEPTH);
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int PIX_W         = 5;
    localparam int REP_W         = 7;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(200);

    localparam int          LEAF_BIT = 7;
    localparam logic [7:0]  RUN_BASE = 8'h90;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MODE_LOAD_TREE = 2'd0,
        MODE_START     = 2'd1,
        MODE_BYTE      = 2'd2,
        MODE_PIXEL     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_NEED_BYTE = 2'd1,
        ST_COMPLETE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PIX,
        S_NEED,
        S_FULL
    } t_state;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] tree_index;
        logic [7:0] tree_entry;
        logic [7:0] code_byte;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_status          status;
        logic             last_pixel;
    } t_out_word;

    typedef struct packed {
        logic               we;
        logic [TREE_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [TREE_AW-1:0] raddr;
    } t_tree_req;

endpackage

`default_nettype wire

/* sv/hrx_tree_mem.sv */
`default_nettype none

module hrx_tree_mem (
    input  wire                logic i_clk,
    input  wire hrx_pkg::t_tree_req  i_req,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [hrx_pkg::TREE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

/* sv/hrx_row_mem.sv */
`default_nettype none

module hrx_row_mem #(
    parameter int MAX_WIDTH = hrx_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [COL_W-1:0]          i_waddr,
    input  wire logic [hrx_pkg::PIX_W-1:0] i_wdata,
    input  wire logic [COL_W-1:0]          i_raddr,
    output logic [hrx_pkg::PIX_W-1:0]      o_rdata
);

    logic [hrx_pkg::PIX_W-1:0] r_mem [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/hrx_ctrl.sv */
`default_nettype none

module hrx_ctrl #(
    parameter int MAX_WIDTH = hrx_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int WW        = $clog2(MAX_WIDTH + 1),
    parameter int TW        = $clog2(MAX_WIDTH * hrx_pkg::MAX_HEIGHT + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_hold,
    input  wire logic [WW-1:0]             i_eff_width,
    input  wire logic [TW-1:0]             i_total,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire hrx_pkg::t_in_word         i_in_word,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output hrx_pkg::t_out_word             o_out_word,
    output hrx_pkg::t_tree_req             o_tree_req,
    input  wire logic [7:0]                i_tree_q,
    output logic                           o_row_we,
    output logic [COL_W-1:0]               o_row_waddr,
    output logic [hrx_pkg::PIX_W-1:0]      o_row_wdata,
    output logic [COL_W-1:0]               o_row_raddr,
    input  wire logic [hrx_pkg::PIX_W-1:0] i_row_q
);

    hrx_pkg::t_state             r_state, n_state;
    logic [7:0]                  r_bit_buf, n_bit_buf;
    logic [3:0]                  r_bits_left, n_bits_left;
    logic [7:0]                  r_walk_node, n_walk_node;
    logic [hrx_pkg::REP_W-1:0]   r_repeat, n_repeat;
    logic [hrx_pkg::PIX_W-1:0]   r_literal, n_literal;
    logic [TW-1:0]               r_done, n_done;
    logic [COL_W-1:0]            r_col, n_col;
    logic [7:0]                  r_tree_addr, n_tree_addr;
    logic                        r_out_valid, n_out_valid;
    hrx_pkg::t_out_word          r_out_word, n_out_word;

    logic                        accept;
    logic                        slot_free;
    logic                        bit_sel;
    logic                        leaf;
    logic                        run_leaf;
    logic [hrx_pkg::PIX_W-1:0]   lit_used;
    logic [hrx_pkg::PIX_W-1:0]   above;
    logic [hrx_pkg::PIX_W-1:0]   pix;
    logic [WW-1:0]               col_inc;
    logic [COL_W-1:0]            col_next;
    logic [TW-1:0]               done_inc;
    logic                        tree_we;

    assign o_in_ready  = (r_state == hrx_pkg::S_IDLE) && !i_hold;
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign bit_sel     = r_bit_buf[3'(r_bits_left - 4'd1)];
    assign leaf        = i_tree_q[hrx_pkg::LEAF_BIT];
    assign run_leaf    = i_tree_q > hrx_pkg::RUN_BASE;
    assign lit_used    = (r_state == hrx_pkg::S_WALK && !run_leaf) ?
                         i_tree_q[hrx_pkg::PIX_W-1:0] : r_literal;
    assign above       = (r_done < TW'(i_eff_width)) ? '0 : i_row_q;
    assign pix         = above ^ lit_used;
    assign col_inc     = WW'(r_col) + WW'(1);
    assign col_next    = (col_inc >= i_eff_width) ? '0 : COL_W'(col_inc);
    assign done_inc    = r_done + TW'(1);

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_row_waddr = r_col;
    assign o_row_wdata = pix;
    assign o_row_raddr = r_col;

    always_comb begin
        o_tree_req.we    = tree_we;
        o_tree_req.waddr = i_in_word.tree_index;
        o_tree_req.wdata = i_in_word.tree_entry;
        o_tree_req.raddr = n_tree_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_bit_buf   = r_bit_buf;
        n_bits_left = r_bits_left;
        n_walk_node = r_walk_node;
        n_repeat    = r_repeat;
        n_literal   = r_literal;
        n_done      = r_done;
        n_col       = r_col;
        n_tree_addr = r_tree_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        tree_we     = 1'b0;
        o_row_we    = 1'b0;

        case (r_state)
            hrx_pkg::S_IDLE: begin
                n_tree_addr = {r_walk_node[6:0], bit_sel};
                if (accept) begin
                    case (i_in_word.mode)
                        hrx_pkg::MODE_LOAD_TREE: begin
                            tree_we = 1'b1;
                        end
                        hrx_pkg::MODE_START: begin
                            n_bit_buf   = '0;
                            n_bits_left = '0;
                            n_walk_node = '0;
                            n_repeat    = '0;
                            n_literal   = '0;
                            n_done      = '0;
                            n_col       = '0;
                        end
                        hrx_pkg::MODE_BYTE: begin
                            n_bit_buf   = i_in_word.code_byte;
                            n_bits_left = 4'd8;
                        end
                        hrx_pkg::MODE_PIXEL: begin
                            if (r_done >= i_total) begin
                                n_state = hrx_pkg::S_FULL;
                            end else if (r_repeat != '0) begin
                                n_state = hrx_pkg::S_PIX;
                            end else if (r_bits_left == 4'd0) begin
                                n_state = hrx_pkg::S_NEED;
                            end else begin
                                n_bits_left = r_bits_left - 4'd1;
                                n_state     = hrx_pkg::S_WALK;
                            end
                        end
                        default: begin
                            n_state = hrx_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            hrx_pkg::S_WALK: begin
                if (leaf) begin
                    if (slot_free) begin
                        n_walk_node = '0;
                        if (run_leaf) begin
                            n_repeat = hrx_pkg::REP_W'(i_tree_q - hrx_pkg::RUN_BASE);
                        end else begin
                            n_literal = i_tree_q[hrx_pkg::PIX_W-1:0];
                        end
                        o_row_we    = 1'b1;
                        n_col       = col_next;
                        n_done      = done_inc;
                        n_out_valid = 1'b1;
                        n_out_word  = '{pixel: pix, status: hrx_pkg::ST_PIXEL,
                                        last_pixel: done_inc == i_total};
                        n_state     = hrx_pkg::S_IDLE;
                    end
                end else if (r_bits_left != 4'd0) begin
                    n_walk_node = i_tree_q;
                    n_bits_left = r_bits_left - 4'd1;
                    n_tree_addr = {i_tree_q[6:0], bit_sel};
                end else if (slot_free) begin
                    n_walk_node = i_tree_q;
                    n_out_valid = 1'b1;
                    n_out_word  = '{pixel: '0, status: hrx_pkg::ST_NEED_BYTE,
                                    last_pixel: 1'b0};
                    n_state     = hrx_pkg::S_IDLE;
                end
            end
            hrx_pkg::S_PIX: begin
                if (slot_free) begin
                    n_repeat    = r_repeat - hrx_pkg::REP_W'(1);
                    o_row_we    = 1'b1;
                    n_col       = col_next;
                    n_done      = done_inc;
                    n_out_valid = 1'b1;
                    n_out_word  = '{pixel: pix, status: hrx_pkg::ST_PIXEL,
                                    last_pixel: done_inc == i_total};
                    n_state     = hrx_pkg::S_IDLE;
                end
            end
            hrx_pkg::S_NEED: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{pixel: '0, status: hrx_pkg::ST_NEED_BYTE,
                                    last_pixel: 1'b0};
                    n_state     = hrx_pkg::S_IDLE;
                end
            end
            hrx_pkg::S_FULL: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{pixel: '0, status: hrx_pkg::ST_COMPLETE,
                                    last_pixel: 1'b0};
                    n_state     = hrx_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hrx_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrx_pkg::S_IDLE;
            r_bit_buf   <= '0;
            r_bits_left <= '0;
            r_walk_node <= '0;
            r_repeat    <= '0;
            r_literal   <= '0;
            r_done      <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_buf   <= n_bit_buf;
            r_bits_left <= n_bits_left;
            r_walk_node <= n_walk_node;
            r_repeat    <= n_repeat;
            r_literal   <= n_literal;
            r_done      <= n_done;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tree_addr <= n_tree_addr;
        r_out_word  <= n_out_word;
    end

endmodule

`default_nettype wire

/* sv/huffman_rle_row_xor_decoder.sv */
// Picture decoder for streams coded as row XOR, then run length, then Huffman.
// Input channel (i_in_valid/o_in_ready, i_in_word) takes one word per command:
// load a tree entry, start an image, supply a compressed byte, or request a
// pixel. Only a pixel request produces an output word (o_out_valid/i_out_ready,
// o_out_word) carrying a pixel, a need-byte status or an image-complete status.
// The configuration channel (i_cfg_valid/o_cfg_ready) writes the image width
// and height and is always ready; input words are held off in the cycle after
// each write while the pixel total is recomputed.
// A pixel request is accepted, then walks the tree memory one code bit at a
// time, or emits a repeated pixel while a run is pending. The tree lookup is
// one synchronous read per bit, and the pixel above comes from the row memory
// in parallel with the walk; no new input word is accepted until it finishes.
// Results sit in an output register; when the receiver stalls, a finished
// request holds its state until the register frees, and no input word is
// accepted meanwhile. Load, start and byte words are still accepted while an
// earlier result waits in the register. Reset restores width 320 and height
// 200 and clears the decoder state; both memories keep their contents and need
// no clearing.
`default_nettype none

module huffman_rle_row_xor_decoder #(
    parameter int MAX_WIDTH = hrx_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire hrx_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output hrx_pkg::t_out_word                     o_out_word,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hrx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hrx_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(hrx_pkg::MAX_HEIGHT + 1);
    localparam int TW    = $clog2(MAX_WIDTH * hrx_pkg::MAX_HEIGHT + 1);
    localparam int EW    = (WW > hrx_pkg::CFG_W) ? WW : hrx_pkg::CFG_W;
    localparam int EH    = (HW > hrx_pkg::CFG_W) ? HW : hrx_pkg::CFG_W;

    logic [hrx_pkg::CFG_W-1:0] r_cfg_width;
    logic [hrx_pkg::CFG_W-1:0] r_cfg_height;
    logic                      r_cfg_dirty;
    logic [WW-1:0]             r_eff_width;
    logic [TW-1:0]             r_total;

    logic [EW-1:0]             width_ext;
    logic [EH-1:0]             height_ext;
    logic [WW-1:0]             n_eff_width;
    logic [HW-1:0]             eff_height;
    logic                      cfg_write;

    hrx_pkg::t_tree_req        tree_req;
    logic [7:0]                tree_q;
    logic                      row_we;
    logic [COL_W-1:0]          row_waddr;
    logic [hrx_pkg::PIX_W-1:0] row_wdata;
    logic [COL_W-1:0]          row_raddr;
    logic [hrx_pkg::PIX_W-1:0] row_q;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        width_ext  = EW'(r_cfg_width);
        height_ext = EH'(r_cfg_height);
        if (width_ext == '0) begin
            n_eff_width = WW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            n_eff_width = WW'(MAX_WIDTH);
        end else begin
            n_eff_width = WW'(width_ext);
        end
        if (height_ext == '0) begin
            eff_height = HW'(1);
        end else if (height_ext > EH'(hrx_pkg::MAX_HEIGHT)) begin
            eff_height = HW'(hrx_pkg::MAX_HEIGHT);
        end else begin
            eff_height = HW'(height_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= hrx_pkg::WIDTH_RESET;
            r_cfg_height <= hrx_pkg::HEIGHT_RESET;
            r_cfg_dirty  <= 1'b1;
        end else begin
            r_cfg_dirty <= cfg_write;
            if (cfg_write && i_cfg_index == hrx_pkg::CFG_IMAGE_WIDTH) begin
                r_cfg_width <= i_cfg_data;
            end
            if (cfg_write && i_cfg_index == hrx_pkg::CFG_IMAGE_HEIGHT) begin
                r_cfg_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff_width <= n_eff_width;
        r_total     <= TW'(n_eff_width * eff_height);
    end

    hrx_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .WW        (WW),
        .TW        (TW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (r_cfg_dirty),
        .i_eff_width (r_eff_width),
        .i_total     (r_total),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_tree_req  (tree_req),
        .i_tree_q    (tree_q),
        .o_row_we    (row_we),
        .o_row_waddr (row_waddr),
        .o_row_wdata (row_wdata),
        .o_row_raddr (row_raddr),
        .i_row_q     (row_q)
    );

    hrx_tree_mem u_tree_mem (
        .i_clk   (i_clk),
        .i_req   (tree_req),
        .o_rdata (tree_q)
    );

    hrx_row_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_q)
    );

endmodule

`default_nettype wire
